@@ design/rsbn_pkg.sv @@
// shared constants, types and codes of the record sorter
`default_nettype none
package rsbn_pkg;

  localparam int RECORDS    = 32;
  localparam int NAME_WORDS = 4;

  localparam int SLOT_W   = 5;
  localparam int RIDX_W   = $clog2(RECORDS);
  localparam int RCNT_W   = $clog2(RECORDS + 1);
  localparam int WIDX_W   = (NAME_WORDS > 1) ? $clog2(NAME_WORDS) : 1;
  localparam int CCNT_W   = $clog2(NAME_WORDS + 1);
  localparam int NADDR_W  = $clog2(RECORDS * NAME_WORDS);

  // per-record side fields, len is the number of name words written
  typedef struct packed {
    logic [CCNT_W-1:0] len;
    logic [31:0]       num;
    logic [30:0]       id;
    logic              empty;
  } rec_info_t;

  // write and read requests into the record store
  typedef struct packed {
    logic               name_we;
    logic [NADDR_W-1:0] name_waddr;
    logic [63:0]        name_wdata;
    logic [NADDR_W-1:0] name_raddr;
    logic               info_we;
    logic [RIDX_W-1:0]  info_waddr;
    rec_info_t          info_wdata;
    logic [RIDX_W-1:0]  info_raddr;
  } store_req_t;

  // outcome of comparing one name word
  typedef enum logic [1:0] {
    CMP_LT   = 2'd0,
    CMP_GT   = 2'd1,
    CMP_END  = 2'd2,
    CMP_MORE = 2'd3
  } cmp_e;

endpackage
`default_nettype wire

@@ design/record_sort_by_name_then_number_core.sv @@
// record sorter top level: loader, insertion-sort sequencer and output
//
//   channel  signals                                         direction
//   input    in_valid_i / in_stall_o, one name chunk a word   in
//   output   out_valid_o / out_stall_i, one record a word     out
//
// loading takes one chunk word per cycle; after the last record the block stalls
// its input while a sequencer runs a stable insertion sort with one word comparator:
// each compare step fetches the previous record's order entry and fields, then
// compares the name words pair by pair until the order is decided; each inserted
// record first fetches its own entry and fields; init fills the order list in order
// reset clears the counters and the sequencer; memory contents are not cleared
`default_nettype none
module record_sort_by_name_then_number_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [63:0] name_chunk_i,
  input  wire logic        chunk_last_i,
  input  wire logic [31:0] tax_number_i,
  input  wire logic [30:0] record_id_i,
  input  wire logic        empty_flag_i,
  input  wire logic        record_last_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [4:0]       slot_o,
  output logic [30:0]      out_id_o,
  output logic [31:0]      out_tax_number_o,
  output logic             out_empty_o,
  output logic             run_last_o,
  output logic             overflow_o
);
  import rsbn_pkg::*;

  typedef enum logic [14:0] {
    S_LOAD     = 15'b000000000000001,
    S_INIT     = 15'b000000000000010,
    S_ISTART   = 15'b000000000000100,
    S_CURWAIT  = 15'b000000000001000,
    S_CURINFO  = 15'b000000000010000,
    S_JCHECK   = 15'b000000000100000,
    S_PREVWAIT = 15'b000000001000000,
    S_PREVINFO = 15'b000000010000000,
    S_WA       = 15'b000000100000000,
    S_WB       = 15'b000001000000000,
    S_WC       = 15'b000010000000000,
    S_OADDR    = 15'b000100000000000,
    S_OWAIT    = 15'b001000000000000,
    S_OINFO    = 15'b010000000000000,
    S_SHOW     = 15'b100000000000000
  } state_e;

  state_e            state_q, state_d;
  logic [RCNT_W-1:0] rec_cnt_q, rec_cnt_d;
  logic [CCNT_W-1:0] chunk_cnt_q, chunk_cnt_d;
  logic              ovf_q, ovf_d;
  logic [RCNT_W-1:0] i_q, i_d;
  logic [RCNT_W-1:0] j_q, j_d;
  logic [WIDX_W-1:0] w_q, w_d;
  logic [RIDX_W-1:0] cur_q, cur_d;
  logic [RIDX_W-1:0] prev_q, prev_d;
  rec_info_t         cur_info_q, cur_info_d;
  rec_info_t         prev_info_q, prev_info_d;
  logic [63:0]       wa_q, wa_d;
  logic [4:0]        slot_q, slot_d;
  rec_info_t         oinfo_q, oinfo_d;
  logic              last_q, last_d;

  // order list memory
  logic [RIDX_W-1:0] order_mem [RECORDS];
  logic [RIDX_W-1:0] ord_rdata_q;
  logic              ord_we;
  logic [RIDX_W-1:0] ord_waddr;
  logic [RIDX_W-1:0] ord_wdata;
  logic [RIDX_W-1:0] ord_raddr;

  store_req_t        req;
  logic [63:0]       name_rdata;
  rec_info_t         info_rdata;
  logic [63:0]       wb_masked;
  cmp_e              cmp_res;

  logic              in_acc;
  logic              rec_ok;
  logic              rec_end;
  logic [CCNT_W-1:0] chunk_next;
  logic [RCNT_W-1:0] j_dec;
  logic [RCNT_W-1:0] i_inc;
  logic              cur_first;
  logic              decided;

  rsbn_record_store u_store (
    .clk_i        (clk_i),
    .req_i        (req),
    .name_rdata_o (name_rdata),
    .info_rdata_o (info_rdata)
  );

  rsbn_word_cmp u_cmp (
    .a_i   (wa_q),
    .b_i   (wb_masked),
    .res_o (cmp_res)
  );

  assign in_stall_o       = (state_q != S_LOAD);
  assign in_acc           = in_valid_i && (state_q == S_LOAD);
  assign rec_ok           = (rec_cnt_q < RCNT_W'(RECORDS));
  assign rec_end          = chunk_last_i || record_last_i;
  assign j_dec            = j_q - RCNT_W'(1);
  assign i_inc            = i_q + RCNT_W'(1);

  assign out_valid_o      = (state_q == S_SHOW);
  assign slot_o           = slot_q;
  assign out_id_o         = oinfo_q.id;
  assign out_tax_number_o = oinfo_q.num;
  assign out_empty_o      = oinfo_q.empty;
  assign run_last_o       = last_q;
  assign overflow_o       = ovf_q;

  // previous record word, zero past its stored length
  assign wb_masked = (CCNT_W'(w_q) < prev_info_q.len) ? name_rdata : 64'd0;

  // final decision of the current compare
  always_comb begin
    cur_first = 1'b0;
    decided   = 1'b1;
    case (cmp_res)
      CMP_LT:  cur_first = 1'b1;
      CMP_GT:  cur_first = 1'b0;
      CMP_END: cur_first = ($signed(cur_info_q.num) < $signed(prev_info_q.num));
      CMP_MORE: begin
        if (w_q == WIDX_W'(NAME_WORDS - 1)) begin
          cur_first = ($signed(cur_info_q.num) < $signed(prev_info_q.num));
        end else begin
          decided = 1'b0;
        end
      end
      default: decided = 1'b1;
    endcase
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    rec_cnt_d   = rec_cnt_q;
    chunk_cnt_d = chunk_cnt_q;
    ovf_d       = ovf_q;
    i_d         = i_q;
    j_d         = j_q;
    w_d         = w_q;
    cur_d       = cur_q;
    prev_d      = prev_q;
    cur_info_d  = cur_info_q;
    prev_info_d = prev_info_q;
    wa_d        = wa_q;
    slot_d      = slot_q;
    oinfo_d     = oinfo_q;
    last_d      = last_q;
    chunk_next  = chunk_cnt_q;
    ord_we      = 1'b0;
    ord_waddr   = '0;
    ord_wdata   = '0;
    ord_raddr   = '0;
    req         = '0;

    case (state_q)
      S_LOAD: begin
        if (in_acc) begin
          // store the chunk word if there is room
          if (rec_ok && (chunk_cnt_q < CCNT_W'(NAME_WORDS))) begin
            req.name_we    = 1'b1;
            req.name_waddr = NADDR_W'(rec_cnt_q) * NADDR_W'(NAME_WORDS)
                             + NADDR_W'(chunk_cnt_q);
            req.name_wdata = name_chunk_i;
            chunk_next     = chunk_cnt_q + CCNT_W'(1);
          end else begin
            ovf_d = 1'b1;
          end
          chunk_cnt_d = chunk_next;
          // close the record
          if (rec_end) begin
            if (rec_ok) begin
              req.info_we          = 1'b1;
              req.info_waddr       = rec_cnt_q[RIDX_W-1:0];
              req.info_wdata.len   = chunk_next;
              req.info_wdata.num   = tax_number_i;
              req.info_wdata.id    = record_id_i;
              req.info_wdata.empty = empty_flag_i;
              rec_cnt_d            = rec_cnt_q + RCNT_W'(1);
            end
            chunk_cnt_d = '0;
          end
          if (record_last_i) begin
            i_d     = '0;
            state_d = S_INIT;
          end
        end
      end
      S_INIT: begin
        if (i_q == rec_cnt_q) begin
          i_d     = RCNT_W'(1);
          j_d     = '0;
          state_d = (rec_cnt_q > RCNT_W'(1)) ? S_ISTART : S_OADDR;
        end else begin
          ord_we    = 1'b1;
          ord_waddr = i_q[RIDX_W-1:0];
          ord_wdata = i_q[RIDX_W-1:0];
          i_d       = i_inc;
        end
      end
      S_ISTART: begin
        ord_raddr = i_q[RIDX_W-1:0];
        j_d       = i_q;
        state_d   = S_CURWAIT;
      end
      S_CURWAIT: begin
        cur_d          = ord_rdata_q;
        req.info_raddr = ord_rdata_q;
        state_d        = S_CURINFO;
      end
      S_CURINFO: begin
        cur_info_d = info_rdata;
        state_d    = S_JCHECK;
      end
      S_JCHECK: begin
        if (j_q == '0) begin
          ord_we    = 1'b1;
          ord_waddr = '0;
          ord_wdata = cur_q;
          i_d       = i_inc;
          j_d       = '0;
          state_d   = (i_inc == rec_cnt_q) ? S_OADDR : S_ISTART;
        end else begin
          ord_raddr = j_dec[RIDX_W-1:0];
          state_d   = S_PREVWAIT;
        end
      end
      S_PREVWAIT: begin
        prev_d         = ord_rdata_q;
        req.info_raddr = ord_rdata_q;
        state_d        = S_PREVINFO;
      end
      S_PREVINFO: begin
        prev_info_d = info_rdata;
        w_d         = '0;
        state_d     = S_WA;
      end
      S_WA: begin
        req.name_raddr = NADDR_W'(cur_q) * NADDR_W'(NAME_WORDS) + NADDR_W'(w_q);
        state_d        = S_WB;
      end
      S_WB: begin
        wa_d           = (CCNT_W'(w_q) < cur_info_q.len) ? name_rdata : 64'd0;
        req.name_raddr = NADDR_W'(prev_q) * NADDR_W'(NAME_WORDS) + NADDR_W'(w_q);
        state_d        = S_WC;
      end
      S_WC: begin
        if (!decided) begin
          w_d     = w_q + WIDX_W'(1);
          state_d = S_WA;
        end else if (cur_first) begin
          // shift the previous entry up one place
          ord_we    = 1'b1;
          ord_waddr = j_q[RIDX_W-1:0];
          ord_wdata = prev_q;
          j_d       = j_dec;
          state_d   = S_JCHECK;
        end else begin
          ord_we    = 1'b1;
          ord_waddr = j_q[RIDX_W-1:0];
          ord_wdata = cur_q;
          i_d       = i_inc;
          j_d       = '0;
          state_d   = (i_inc == rec_cnt_q) ? S_OADDR : S_ISTART;
        end
      end
      S_OADDR: begin
        ord_raddr = j_q[RIDX_W-1:0];
        state_d   = S_OWAIT;
      end
      S_OWAIT: begin
        slot_d         = 5'(ord_rdata_q);
        req.info_raddr = ord_rdata_q;
        state_d        = S_OINFO;
      end
      S_OINFO: begin
        oinfo_d = info_rdata;
        last_d  = (j_q + RCNT_W'(1) == rec_cnt_q);
        state_d = S_SHOW;
      end
      S_SHOW: begin
        if (!out_stall_i) begin
          if (last_q) begin
            rec_cnt_d   = '0;
            chunk_cnt_d = '0;
            ovf_d       = 1'b0;
            state_d     = S_LOAD;
          end else begin
            j_d     = j_q + RCNT_W'(1);
            state_d = S_OADDR;
          end
        end
      end
      default: state_d = S_LOAD;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      rec_cnt_q   <= '0;
      chunk_cnt_q <= '0;
      ovf_q       <= 1'b0;
      i_q         <= '0;
      j_q         <= '0;
      w_q         <= '0;
      last_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      rec_cnt_q   <= rec_cnt_d;
      chunk_cnt_q <= chunk_cnt_d;
      ovf_q       <= ovf_d;
      i_q         <= i_d;
      j_q         <= j_d;
      w_q         <= w_d;
      last_q      <= last_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cur_q       <= cur_d;
    prev_q      <= prev_d;
    cur_info_q  <= cur_info_d;
    prev_info_q <= prev_info_d;
    wa_q        <= wa_d;
    slot_q      <= slot_d;
    oinfo_q     <= oinfo_d;
  end

  // order list, one write and one registered read
  always_ff @(posedge clk_i) begin
    if (ord_we) begin
      order_mem[ord_waddr] <= ord_wdata;
    end
    ord_rdata_q <= order_mem[ord_raddr];
  end

endmodule
`default_nettype wire

@@ design/rsbn_word_cmp.sv @@
// strcmp step over one 64-bit name word, first byte most significant
`default_nettype none
module rsbn_word_cmp (
  input  wire logic [63:0]  a_i,
  input  wire logic [63:0]  b_i,
  output rsbn_pkg::cmp_e    res_o
);
  import rsbn_pkg::*;

  // first differing byte decides, a zero byte in both ends the name
  always_comb begin
    logic       done;
    logic [7:0] ca;
    logic [7:0] cb;
    done  = 1'b0;
    res_o = CMP_MORE;
    for (int k = 0; k < 8; k++) begin
      ca = a_i[63 - 8*k -: 8];
      cb = b_i[63 - 8*k -: 8];
      if (!done) begin
        if (ca != cb) begin
          res_o = (ca < cb) ? CMP_LT : CMP_GT;
          done  = 1'b1;
        end else if (ca == 8'd0) begin
          res_o = CMP_END;
          done  = 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

@@ design/rsbn_record_store.sv @@
// name memory and per-record field memory, registered reads
`default_nettype none
module rsbn_record_store (
  input  wire logic                 clk_i,
  input  wire rsbn_pkg::store_req_t req_i,
  output logic [63:0]               name_rdata_o,
  output rsbn_pkg::rec_info_t       info_rdata_o
);
  import rsbn_pkg::*;

  logic [63:0] name_mem [RECORDS*NAME_WORDS];
  rec_info_t   info_mem [RECORDS];

  // name words
  always_ff @(posedge clk_i) begin
    if (req_i.name_we) begin
      name_mem[req_i.name_waddr] <= req_i.name_wdata;
    end
    name_rdata_o <= name_mem[req_i.name_raddr];
  end

  // number, id, flag and length
  always_ff @(posedge clk_i) begin
    if (req_i.info_we) begin
      info_mem[req_i.info_waddr] <= req_i.info_wdata;
    end
    info_rdata_o <= info_mem[req_i.info_raddr];
  end

endmodule
`default_nettype wire
